FILE: hdl/modular_exponentiation_macros.svh
// assertion macros shared by the modular exponentiation rtl
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clock, rstn, ante, cons)
`define ASSERT_NEXT(label, clock, rstn, ante, cons)
`endif

`endif

FILE: hdl/mexp_pkg.sv
// shared types and constants for the modular exponentiation block
package mexp_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

	// configuration port
	localparam int ADDR_W = 3;
	localparam logic REG_MODULUS = 1'b0;

	typedef enum logic {
		OP_POWER   = 1'b0,
		OP_INVERSE = 1'b1
	} op_t;

	typedef enum logic {
		AR_MUL = 1'b0,
		AR_RED = 1'b1
	} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED_GO,
		ST_RED_WAIT,
		ST_STEP,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_SQR_GO,
		ST_SQR_WAIT
	} state_t;

	// done state shares nothing with the others, kept apart for clarity
	typedef enum logic {
		OUT_IDLE,
		OUT_SHOW
	} out_state_t;

endpackage

FILE: hdl/modular_exponentiation.sv
// top level: modular exponentiation and fermat inverse by square-and-multiply
//
// usage
//   command channel: drive operation, base and exponent with start high; the
//   transaction is taken at a rising edge where start is high and busy is low.
//   busy stays high until the result has been shown.
//   result channel: result is valid for exactly one cycle while done is high;
//   the receiver cannot stall it and must take it in that cycle.
//   configuration: apb write of the modulus at byte address 0, only while the
//   block is not busy; pready is always high; reads at paddr[2]=0 give the modulus.
// timing
//   one shared bit-serial multiplier does all the work, one operand bit per
//   cycle. the base is reduced first, then each exponent bit costs a step
//   state, a multiply if the bit is set and a square unless it is the top
//   bit; a square or multiply runs over the bits of the current base up to
//   its top set bit. a zero exponent is answered the cycle after the command.
//   one transaction at a time, the next is taken the cycle after done.
// reset
//   arst_n clears the sequencer and loads the modulus with 1000000007.
module modular_exponentiation #(
	parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        operation,
	input  logic [31:0]                 base,
	input  logic [31:0]                 exponent,
	output logic                        done,
	output logic [31:0]                 result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mexp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import mexp_pkg::*;

	localparam logic [31:0] MOD_MASK = (WORD_BITS >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << WORD_BITS) - 64'd1);

	state_t               state_q;
	state_t               state_nx;
	out_state_t           out_q;
	logic [31:0]          mod_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] pb_q;
	logic [WORD_BITS-1:0] e_q;

	logic                 accept;
	logic [WORD_BITS-1:0] m;
	logic [WORD_BITS-1:0] e_init;
	logic [WORD_BITS-1:0] acc_init;
	logic                 finish_now;
	arith_req_t           mm_req;
	logic [WORD_BITS-1:0] mm_a;
	logic                 mm_done;
	logic [WORD_BITS-1:0] mm_y;
	logic                 reg_sel;

	// configuration port
	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_W-1] == REG_MODULUS);
	assign prdata  = reg_sel ? mod_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mod_q <= MODULUS_RESET & MOD_MASK;
		else if (psel && penable && pwrite && pready && reg_sel)
			mod_q <= pwdata & MOD_MASK;
	end

	// command decode
	always_comb begin
		accept = start && !busy;
		m      = WORD_BITS'(mod_q);
		if (op_t'(operation) == OP_INVERSE)
			e_init = (m < WORD_BITS'(2)) ? '0 : m - WORD_BITS'(2);
		else
			e_init = WORD_BITS'(exponent);
		// a modulus of one sends every product to zero
		acc_init   = (e_init != '0 && m == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
		finish_now = (e_q >> 1) == '0;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:     if (accept && e_init != '0) state_nx = ST_RED_GO;
			ST_RED_GO:   state_nx = ST_RED_WAIT;
			ST_RED_WAIT: if (mm_done) state_nx = ST_STEP;
			ST_STEP:     state_nx = e_q[0] ? ST_MUL_GO : ST_SQR_GO;
			ST_MUL_GO:   state_nx = ST_MUL_WAIT;
			ST_MUL_WAIT: if (mm_done) state_nx = finish_now ? ST_IDLE : ST_SQR_GO;
			ST_SQR_GO:   state_nx = ST_SQR_WAIT;
			ST_SQR_WAIT: if (mm_done) state_nx = ST_STEP;
		endcase
	end

	// outputs
	always_comb begin
		mm_req.start = 1'b0;
		mm_req.op    = AR_MUL;
		mm_a         = pb_q;
		unique case (state_q)
			ST_RED_GO: begin
				mm_req.start = 1'b1;
				mm_req.op    = AR_RED;
			end
			ST_MUL_GO: begin
				mm_req.start = 1'b1;
				mm_a         = acc_q;
			end
			ST_SQR_GO: mm_req.start = 1'b1;
			default: ;
		endcase
		busy   = (state_q != ST_IDLE) || (out_q == OUT_SHOW);
		done   = (out_q == OUT_SHOW);
		result = 32'(acc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_q   <= OUT_IDLE;
		end else begin
			state_q <= state_nx;
			if ((state_q == ST_IDLE && accept && e_init == '0) ||
			    (state_q == ST_MUL_WAIT && mm_done && finish_now))
				out_q <= OUT_SHOW;
			else
				out_q <= OUT_IDLE;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pb_q  <= WORD_BITS'(base);
			e_q   <= e_init;
			acc_q <= acc_init;
		end else if (mm_done) begin
			case (state_q)
				ST_RED_WAIT: pb_q <= mm_y;
				ST_MUL_WAIT: acc_q <= mm_y;
				ST_SQR_WAIT: begin
					pb_q <= mm_y;
					e_q  <= e_q >> 1;
				end
				default: ;
			endcase
		end
	end

	mexp_mulmod #(
		.WORD_BITS(WORD_BITS)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.a      (mm_a),
		.b      (pb_q),
		.m      (m),
		.done   (mm_done),
		.y      (mm_y)
	);

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_IMPLIES(a_done_busy, clk, arst_n, done, busy && state_q == ST_IDLE)
	`ASSERT_NEXT(a_done_single, clk, arst_n, done, !done && !busy)
	`ASSERT_IMPLIES(a_step_nonzero, clk, arst_n, state_q == ST_STEP, e_q != '0)

endmodule

FILE: hdl/mexp_mulmod.sv
// bit-serial modular multiplier and reducer, one operand bit per cycle
`include "modular_exponentiation_macros.svh"

module mexp_mulmod #(
	parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mexp_pkg::arith_req_t    req,
	input  logic [WORD_BITS-1:0]    a,
	input  logic [WORD_BITS-1:0]    b,
	input  logic [WORD_BITS-1:0]    m,
	output logic                    done,
	output logic [WORD_BITS-1:0]    y
);
	import mexp_pkg::*;

	localparam int CNT_W = $clog2(WORD_BITS + 1);

	logic                 run_q;
	arith_op_t            op_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] b_q;
	logic [WORD_BITS-1:0] acc_q;

	logic [WORD_BITS:0]   mext;
	logic [WORD_BITS:0]   sum_acc;
	logic [WORD_BITS:0]   sum_dbl;
	logic [WORD_BITS:0]   shl;
	logic [WORD_BITS-1:0] acc_add;
	logic [WORD_BITS-1:0] a_dbl;
	logic [WORD_BITS-1:0] acc_red;
	logic                 finish;

	always_comb begin
		// a modulus of zero stands for 2^WORD_BITS
		mext    = {(m == '0), m};
		sum_acc = {1'b0, acc_q} + {1'b0, a_q};
		sum_dbl = {1'b0, a_q} + {1'b0, a_q};
		shl     = {acc_q, b_q[WORD_BITS-1]};
		acc_add = (sum_acc >= mext) ? WORD_BITS'(sum_acc - mext) : WORD_BITS'(sum_acc);
		a_dbl   = (sum_dbl >= mext) ? WORD_BITS'(sum_dbl - mext) : WORD_BITS'(sum_dbl);
		acc_red = (shl >= mext) ? WORD_BITS'(shl - mext) : WORD_BITS'(shl);
		finish  = 1'b1;
		unique case (op_q)
			AR_MUL: finish = (b_q == '0);
			AR_RED: finish = (cnt_q == '0);
		endcase
	end

	assign done = run_q && finish;
	assign y    = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			op_q  <= AR_MUL;
			cnt_q <= '0;
		end else if (req.start) begin
			run_q <= 1'b1;
			op_q  <= req.op;
			cnt_q <= CNT_W'(WORD_BITS);
		end else if (done) begin
			run_q <= 1'b0;
		end else if (run_q && op_q == AR_RED) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q && !finish) begin
			case (op_q)
				AR_MUL: begin
					// lsb first: add the multiplicand, then double it
					if (b_q[0])
						acc_q <= acc_add;
					a_q <= a_dbl;
					b_q <= b_q >> 1;
				end
				default: begin
					// msb first remainder: acc = 2*acc + bit mod m
					acc_q <= acc_red;
					b_q   <= b_q << 1;
				end
			endcase
		end
	end

	`ASSERT_IMPLIES(a_start_idle, clk, arst_n, req.start, !run_q)
	`ASSERT_IMPLIES(a_acc_reduced, clk, arst_n, run_q, ({1'b0, acc_q} < mext))
	`ASSERT_NEXT(a_done_stops, clk, arst_n, done && !req.start, !run_q)

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the modular exponentiation block: directed and random commands
`timescale 1ns / 100ps

module testbench;
	import mexp_pkg::*;

	localparam int HOLD_CYCLES = 2400;
	localparam int PHASES = 13;
	localparam int PHASE_ITEMS = 146;
	localparam logic [ADDR_W-1:0] MODULUS_ADDR = ADDR_W'(4 * REG_MODULUS);

	typedef struct {
		op_t         op;
		logic [31:0] base;
		logic [31:0] exponent;
	} cmd_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              operation = OP_POWER;
	logic [31:0]       base = '0;
	logic [31:0]       exponent = '0;
	logic              done;
	logic [31:0]       result;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	cmd_t        pending_cmds[$];
	logic [31:0] expected_results[$];
	logic [31:0] modulus_model = MODULUS_RESET;
	logic [31:0] phase_mod [PHASES];
	int          gap_pct = 0;
	int          fail_count = 0;

	modular_exponentiation dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.operation(operation),
		.base     (base),
		.exponent (exponent),
		.done     (done),
		.result   (result),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// (a * b) mod m, a zero modulus wraps at 32 bits
	function automatic logic [31:0] mul_mod(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] m);
		logic [63:0] prod;
		logic [63:0] m64;
		m64 = {32'd0, m};
		prod = {32'd0, a} * {32'd0, b};
		if (m == 32'd0)
			return prod[31:0];
		prod = prod % m64;
		return prod[31:0];
	endfunction

	function automatic logic [31:0] pow_mod(input logic [31:0] b, input logic [31:0] e,
		input logic [31:0] m);
		logic [31:0] acc;
		logic [31:0] sq;
		logic [31:0] bits;
		acc = 32'd1;
		sq = b;
		bits = e;
		if (m != 32'd0)
			sq = sq % m;
		while (bits != 0) begin
			if (bits[0])
				acc = mul_mod(acc, sq, m);
			sq = mul_mod(sq, sq, m);
			bits = bits >> 1;
		end
		return acc;
	endfunction

	function automatic logic [31:0] predict_power(input cmd_t c, input logic [31:0] m);
		if (c.op == OP_INVERSE)
			return (m < 2) ? 32'd1 : pow_mod(c.base, m - 32'd2, m);
		return pow_mod(c.base, c.exponent, m);
	endfunction

	// command driver: hold start until taken, then maybe idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.push_back(predict_power(pending_cmds[0], modulus_model));
				pending_cmds.pop_front();
			end
			if (!(start && busy)) begin
				if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
					start <= 1'b1;
					operation <= pending_cmds[0].op;
					base <= pending_cmds[0].base;
					exponent <= pending_cmds[0].exponent;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result: no transaction expected, actual %h", result);
				fail_count++;
			end else begin
				if (result !== expected_results[0]) begin
					$error("result: expected %h, actual %h", expected_results[0], result);
					fail_count++;
				end
				expected_results.pop_front();
			end
		end
	end

	task automatic wait_idle();
		while (pending_cmds.size() != 0 || expected_results.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic apb_read(output logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= MODULUS_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_modulus(input logic [31:0] value);
		logic [31:0] rd;
		wait_idle();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MODULUS_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		modulus_model = value;
		apb_read(rd);
		if (rd !== value) begin
			$error("modulus: expected %h, actual %h", value, rd);
			fail_count++;
		end
	endtask

	task automatic queue_cmd(input op_t op, input logic [31:0] b, input logic [31:0] e);
		cmd_t c;
		c.op = op;
		c.base = b;
		c.exponent = e;
		pending_cmds.push_back(c);
	endtask

	task automatic queue_random(input int count);
		cmd_t c;
		for (int i = 0; i < count; i++) begin
			c.op = ($urandom_range(0, 3) == 0) ? OP_INVERSE : OP_POWER;
			case ($urandom_range(0, 5))
				0: c.base = $urandom;
				1: c.base = $urandom_range(0, 15);
				2: c.base = modulus_model - $urandom_range(0, 2);
				3: c.base = modulus_model + $urandom_range(0, 2);
				4: c.base = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
				default: c.base = $urandom & $urandom;
			endcase
			// mostly short exponents keep the run time down
			case ($urandom_range(0, 7))
				0: c.exponent = 32'h0;
				1: c.exponent = 32'hFFFF_FFFF;
				2, 3: c.exponent = $urandom;
				default: c.exponent = $urandom >> $urandom_range(1, 31);
			endcase
			pending_cmds.push_back(c);
		end
	endtask

	initial begin
		logic [31:0] rd;
		phase_mod[0] = 32'd1000000007;
		phase_mod[1] = 32'hFFFF_FFFB;
		phase_mod[2] = 32'hFFFF_FFFF;
		phase_mod[3] = 32'h0;
		phase_mod[4] = 32'd1;
		phase_mod[5] = 32'd2;
		phase_mod[6] = 32'd3;
		phase_mod[7] = 32'd65537;
		phase_mod[8] = 32'd998244353;
		phase_mod[9] = 32'h7FFF_FFFF;
		phase_mod[10] = $urandom;
		phase_mod[11] = $urandom | 32'h8000_0001;
		phase_mod[12] = $urandom_range(2, 1000);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_read(rd);
		if (rd !== MODULUS_RESET) begin
			$error("modulus: expected %h, actual %h", MODULUS_RESET, rd);
			fail_count++;
		end

		// directed part under the reset modulus
		queue_cmd(OP_POWER, 32'h0, 32'h0);
		queue_cmd(OP_POWER, 32'hFFFF_FFFF, 32'h0);
		queue_cmd(OP_POWER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_cmd(OP_POWER, 32'd2, 32'd10);
		queue_cmd(OP_POWER, 32'd1000000008, 32'd1);
		queue_cmd(OP_INVERSE, 32'd2, 32'h0);
		queue_cmd(OP_INVERSE, 32'h0, 32'hFFFF_FFFF);
		queue_cmd(OP_INVERSE, 32'hFFFF_FFFF, 32'd5);
		queue_cmd(OP_INVERSE, 32'd1000000007, 32'd0);

		// modulus one: zero exponent still gives one
		set_modulus(32'd1);
		queue_cmd(OP_POWER, 32'd5, 32'h0);
		queue_cmd(OP_POWER, 32'd5, 32'd3);
		queue_cmd(OP_INVERSE, 32'd7, 32'd0);

		// modulus zero wraps at the word width
		set_modulus(32'h0);
		queue_cmd(OP_POWER, 32'hFFFF_FFFF, 32'd2);
		queue_cmd(OP_POWER, 32'd3, 32'hFFFF_FFFF);
		queue_cmd(OP_INVERSE, 32'd9, 32'd4);

		set_modulus(32'd2);
		queue_cmd(OP_INVERSE, 32'd3, 32'd0);
		queue_cmd(OP_POWER, 32'd3, 32'd7);

		// composite modulus and shared factor, no error flagged
		set_modulus(32'd15);
		queue_cmd(OP_INVERSE, 32'd4, 32'd0);
		queue_cmd(OP_INVERSE, 32'd6, 32'd0);

		set_modulus(32'hFFFF_FFFF);
		queue_cmd(OP_POWER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_cmd(OP_INVERSE, 32'd2, 32'd0);

		for (int p = 0; p < PHASES; p++) begin
			set_modulus(phase_mod[p]);
			gap_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 49 : 10);
			queue_random(PHASE_ITEMS);
		end

		wait_idle();
		repeat (HOLD_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
